[hw/rtl/sorted_multiset_linked_table_defines.svh]
// Assertion macros for the sorted multiset block.
`ifndef SORTED_MULTISET_LINKED_TABLE_DEFINES_SVH
`define SORTED_MULTISET_LINKED_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SMLT_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SMLT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SMLT_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SMLT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[hw/rtl/smlt_pkg.sv]
`timescale 1ns / 1ps
package smlt_pkg;
  localparam int NODE_CAPACITY = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS = $clog2(NODE_CAPACITY + 1);
  localparam int ADDR_BITS = $clog2(NODE_CAPACITY);
  localparam int STEP_BITS = $clog2(NODE_CAPACITY + 1);
  localparam logic [IDX_BITS-1:0] NIL_INDEX = IDX_BITS'(NODE_CAPACITY);
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_REMOVE_ONE = 2'd1;
  localparam logic [1:0] CMD_REMOVE_N = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic signed [31:0] value;
    logic [31:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [31:0] occurrences;
    logic found;
    logic [1:0] status;
    logic [31:0] total_size;
    logic is_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_NEXT,
    ST_UPD,
    ST_UNLINK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic init_step;
    logic load;
    logic start_walk;
    logic read_cur;
    logic advance;
    logic update;
    logic unlink;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic zero_amount;
    logic cur_nil;
    logic cur_greater;
    logic cur_equal;
    logic steps_done;
    logic need_unlink;
  } stat_t;
endpackage

[hw/rtl/smlt_ctrl.sv]
`timescale 1ns / 1ps
module smlt_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_busy,
  input  smlt_pkg::stat_t st,
  output smlt_pkg::cmd_t cmd
);
  import smlt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (st.init_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = !out_busy;
        if (in_valid && !out_busy) begin
          cmd.load = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (st.zero_amount) state_next = ST_DONE;
        else begin
          cmd.start_walk = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.cur_nil || st.steps_done) state_next = ST_UPD;
        else begin
          cmd.read_cur = 1'b1;
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (st.cur_greater || st.cur_equal) state_next = ST_UPD;
        else begin
          cmd.advance = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = st.need_unlink ? ST_UNLINK : ST_DONE;
      end
      ST_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

[hw/rtl/smlt_datapath.sv]
`timescale 1ns / 1ps
module smlt_datapath (
  input  logic clk,
  input  logic rst,
  input  smlt_pkg::cmd_t cmd,
  output smlt_pkg::stat_t st,
  input  smlt_pkg::in_item_t in_item,
  output smlt_pkg::out_item_t result,
  output logic [smlt_pkg::IDX_BITS-1:0] free_head_o
);
  import smlt_pkg::*;

  logic signed [VALUE_BITS-1:0] mem_value [NODE_CAPACITY];
  logic [31:0] mem_count [NODE_CAPACITY];
  logic [IDX_BITS-1:0] mem_next [NODE_CAPACITY];

  logic [IDX_BITS-1:0] list_head, free_head, prev, cur;
  logic [31:0] total;
  logic [STEP_BITS-1:0] steps;
  logic [ADDR_BITS-1:0] init_addr;
  logic [1:0] command;
  logic signed [VALUE_BITS-1:0] value;
  logic [31:0] amount;
  logic hit;
  logic signed [VALUE_BITS-1:0] rd_value;
  logic [31:0] rd_count;
  logic [IDX_BITS-1:0] rd_next;
  logic [IDX_BITS-1:0] fh_next;
  logic [IDX_BITS-1:0] cur_next;
  logic [31:0] occ;
  logic [1:0] status;
  logic found;
  logic [31:0] want;

  function automatic logic [31:0] occ_rm();
    return (rd_count > want) ? want : rd_count;
  endfunction

  assign free_head_o = free_head;
  assign st.init_last = (init_addr == ADDR_BITS'(NODE_CAPACITY - 1));
  assign st.zero_amount = (command == CMD_REMOVE_N) && (amount == 32'd0);
  assign st.cur_nil = (cur >= NIL_INDEX);
  assign st.steps_done = (steps == STEP_BITS'(NODE_CAPACITY));
  assign st.cur_greater = (rd_value > value);
  assign st.cur_equal = (rd_value == value);
  assign want = (command == CMD_REMOVE_ONE) ? 32'd1 : amount;
  assign st.need_unlink = hit && (command == CMD_REMOVE_ONE || command == CMD_REMOVE_N)
                          && !(rd_count > want);

  always_ff @(posedge clk) begin
    if (cmd.read_cur) begin
      rd_value <= mem_value[cur[ADDR_BITS-1:0]];
      rd_count <= mem_count[cur[ADDR_BITS-1:0]];
      rd_next <= mem_next[cur[ADDR_BITS-1:0]];
    end
    if (!free_head[IDX_BITS-1] || NIL_INDEX != {1'b1, {(IDX_BITS-1){1'b0}}})
      fh_next <= mem_next[free_head[ADDR_BITS-1:0]];
    cur_next <= mem_next[cur[ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      mem_next[init_addr] <= IDX_BITS'(init_addr) + IDX_BITS'(1);
    end else if (cmd.update) begin
      if (command == CMD_ADD && !hit && free_head < NIL_INDEX) begin
        mem_value[free_head[ADDR_BITS-1:0]] <= value;
        mem_count[free_head[ADDR_BITS-1:0]] <= 32'd1;
        mem_next[free_head[ADDR_BITS-1:0]] <= cur;
      end else if (hit && command == CMD_ADD && rd_count != COUNT_MAX) begin
        mem_count[cur[ADDR_BITS-1:0]] <= rd_count + 32'd1;
      end else if (hit && (command == CMD_REMOVE_ONE || command == CMD_REMOVE_N)
                   && rd_count > want) begin
        mem_count[cur[ADDR_BITS-1:0]] <= rd_count - want;
      end
    end else if (cmd.unlink) begin
      mem_next[cur[ADDR_BITS-1:0]] <= free_head;
    end
    if (cmd.update && command == CMD_ADD && !hit && free_head < NIL_INDEX
        && prev < NIL_INDEX)
      mem_next[prev[ADDR_BITS-1:0]] <= free_head;
    if (cmd.unlink && prev < NIL_INDEX)
      mem_next[prev[ADDR_BITS-1:0]] <= cur_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_addr <= '0;
      list_head <= NIL_INDEX;
      free_head <= '0;
      total <= '0;
    end else begin
      if (cmd.init_step && !st.init_last) init_addr <= init_addr + ADDR_BITS'(1);
      if (cmd.update) begin
        if (command == CMD_ADD && !hit && free_head < NIL_INDEX) begin
          free_head <= fh_next;
          if (prev >= NIL_INDEX) list_head <= free_head;
          if (total != COUNT_MAX) total <= total + 32'd1;
        end else if (hit && command == CMD_ADD && rd_count != COUNT_MAX) begin
          if (total != COUNT_MAX) total <= total + 32'd1;
        end else if (hit && (command == CMD_REMOVE_ONE || command == CMD_REMOVE_N)) begin
          total <= (total > occ_rm()) ? total - occ_rm() : 32'd0;
        end
      end
      if (cmd.unlink) begin
        if (prev >= NIL_INDEX) list_head <= cur_next;
        free_head <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command <= in_item.command;
      value <= VALUE_BITS'(in_item.value);
      amount <= in_item.amount;
      hit <= 1'b0;
    end
    if (cmd.start_walk) begin
      prev <= NIL_INDEX;
      cur <= list_head;
      steps <= '0;
    end
    if (cmd.read_cur) steps <= steps + STEP_BITS'(1);
    if (cmd.advance) begin
      prev <= cur;
      cur <= (rd_next >= NIL_INDEX) ? NIL_INDEX : rd_next;
    end
    if (!cmd.read_cur && !cmd.advance && !cmd.start_walk && !cmd.load
        && !cmd.update && !cmd.unlink && !cmd.finish && !cmd.init_step) begin
      if (st.cur_equal && !st.cur_nil && steps != '0) hit <= 1'b1;
    end
    if (cmd.advance || cmd.start_walk) hit <= 1'b0;
    if (cmd.update) begin
      found <= hit;
      if (command == CMD_ADD && !hit && free_head >= NIL_INDEX) status <= STATUS_FULL;
      else status <= STATUS_OK;
      if (command == CMD_ADD) begin
        if (hit) occ <= (rd_count != COUNT_MAX) ? rd_count + 32'd1 : rd_count;
        else if (free_head >= NIL_INDEX) occ <= 32'd0;
        else occ <= 32'd1;
      end else if (command == CMD_QUERY) begin
        occ <= hit ? rd_count : 32'd0;
      end else if (hit) begin
        occ <= occ_rm();
      end else begin
        occ <= 32'd0;
      end
    end
  end

  logic zero_done;
  always_ff @(posedge clk) begin
    if (cmd.load) zero_done <= 1'b1;
    if (cmd.start_walk) zero_done <= 1'b0;
  end

  assign result.occurrences = zero_done ? 32'd0 : occ;
  assign result.found = zero_done ? 1'b0 : found;
  assign result.status = zero_done ? STATUS_ZERO : status;
  assign result.total_size = total;
  assign result.is_empty = (list_head >= NIL_INDEX);
endmodule

[hw/rtl/sorted_multiset_linked_table.sv]
`timescale 1ns / 1ps
// Sorted multiset: a bag of signed 32-bit values kept as an ascending chain
// of distinct values with counts, in a 64-node store with a free chain.
// Input channel in_valid/in_ready carries one command beat (add one,
// remove one, remove up to amount, query). Output channel out_valid/
// out_ready carries one result beat per command.
// Each command walks the chain from its head, reading one node at a time
// through a registered read, until it meets a node not less than the
// value, runs past the last node, or has visited 64 nodes; a node that a
// removal empties is then unlinked onto the free chain. A command with a
// zero removal amount skips the walk.
// One command is handled at a time; the next command beat is taken the
// cycle after the result beat is accepted.
// Reset: the block links the free chain, one node a cycle, with in_ready
// low; the bag is then empty.
// Stall: the result is held in an output register; the next command is
// taken only once that result beat has been accepted.
`include "sorted_multiset_linked_table_defines.svh"
module sorted_multiset_linked_table (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  smlt_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output smlt_pkg::out_item_t out_data
);
  import smlt_pkg::*;

  cmd_t cmd;
  stat_t st;
  out_item_t result;
  logic [IDX_BITS-1:0] free_head;

  smlt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_busy(out_valid), .st(st), .cmd(cmd)
  );

  smlt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .in_item(in_data),
    .result(result), .free_head_o(free_head)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data <= result;
  end

  `SMLT_ASSERT_IMPL(a_no_accept_busy, clk, rst, !(in_ready && out_valid), "accept while busy")
  `SMLT_ASSERT_IMPL(a_finish_idle_out, clk, rst, cmd.finish |-> !out_valid, "result overwritten")
  `SMLT_ASSERT_IMPL(a_free_range, clk, rst, free_head <= NIL_INDEX, "free head out of range")
endmodule

[verif/sorted_multiset_linked_table_tb.sv]
`timescale 1ns / 1ps
module sorted_multiset_linked_table_tb;
  import smlt_pkg::*;

  localparam int CAP = NODE_CAPACITY;
  localparam int NIL = NODE_CAPACITY;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  always #2 clk = ~clk;

  sorted_multiset_linked_table u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  logic signed [31:0] bag_value [CAP];
  logic [31:0] bag_count [CAP];
  int bag_next [CAP];
  int bag_head;
  int bag_free;
  logic [31:0] bag_total;

  out_item_t pending_results [$];
  int errors = 0;
  bit send_gaps = 1'b1;
  bit sink_gaps = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void bag_clear();
    for (int i = 0; i < CAP; i++) begin
      bag_value[i] = '0;
      bag_count[i] = '0;
      bag_next[i] = i + 1;
    end
    bag_head = NIL;
    bag_free = 0;
    bag_total = '0;
  endfunction

  function automatic void bag_total_sub(input logic [31:0] n);
    bag_total = (bag_total > n) ? bag_total - n : 32'd0;
  endfunction

  function automatic out_item_t bag_apply(input in_item_t it);
    out_item_t r;
    int p, c, n;
    bit hit;
    logic [31:0] want;
    r = '0;
    r.status = STATUS_OK;
    if (it.command == CMD_REMOVE_N && it.amount == 0) begin
      r.status = STATUS_ZERO;
    end else begin
      p = NIL;
      c = bag_head;
      hit = 1'b0;
      for (int s = 0; s < CAP; s++) begin
        if (c >= NIL || bag_value[c] > it.value) break;
        if (bag_value[c] == it.value) begin
          hit = 1'b1;
          break;
        end
        p = c;
        c = bag_next[c];
      end
      if (c >= NIL) c = NIL;
      r.found = hit;
      case (it.command)
        CMD_ADD: begin
          if (hit) begin
            if (bag_count[c] != COUNT_MAX) begin
              bag_count[c]++;
              if (bag_total != COUNT_MAX) bag_total++;
            end
            r.occurrences = bag_count[c];
          end else if (bag_free >= NIL) begin
            r.status = STATUS_FULL;
          end else begin
            n = bag_free;
            bag_free = bag_next[n];
            bag_value[n] = it.value;
            bag_count[n] = 1;
            bag_next[n] = c;
            if (p >= NIL) bag_head = n;
            else bag_next[p] = n;
            if (bag_total != COUNT_MAX) bag_total++;
            r.occurrences = 1;
          end
        end
        CMD_REMOVE_ONE, CMD_REMOVE_N: begin
          if (hit) begin
            want = (it.command == CMD_REMOVE_ONE) ? 32'd1 : it.amount;
            if (bag_count[c] > want) begin
              bag_count[c] -= want;
              r.occurrences = want;
            end else begin
              r.occurrences = bag_count[c];
              if (p >= NIL) bag_head = bag_next[c];
              else bag_next[p] = bag_next[c];
              bag_next[c] = bag_free;
              bag_free = c;
            end
            bag_total_sub(r.occurrences);
          end
        end
        default: r.occurrences = hit ? bag_count[c] : 32'd0;
      endcase
    end
    r.total_size = bag_total;
    r.is_empty = (bag_head >= NIL);
    return r;
  endfunction

  task automatic send_beat(input logic [1:0] cmd, input logic signed [31:0] v,
                           input logic [31:0] amt);
    in_item_t it;
    it.command = cmd;
    it.value = v;
    it.amount = amt;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(bag_apply(it));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (sink_gaps && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", out_data.occurrences, 32'd0);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.occurrences !== exp_r.occurrences)
          report_mismatch("occurrences", out_data.occurrences, exp_r.occurrences);
        if (out_data.found !== exp_r.found)
          report_mismatch("found", 32'(out_data.found), 32'(exp_r.found));
        if (out_data.status !== exp_r.status)
          report_mismatch("status", 32'(out_data.status), 32'(exp_r.status));
        if (out_data.total_size !== exp_r.total_size)
          report_mismatch("total_size", out_data.total_size, exp_r.total_size);
        if (out_data.is_empty !== exp_r.is_empty)
          report_mismatch("is_empty", 32'(out_data.is_empty), 32'(exp_r.is_empty));
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15) - 8;
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom_range(0, 79) * 32'sd50_000_000 - 32'sd1_900_000_000;
    endcase
  endfunction

  function automatic logic [31:0] pick_amount();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom();
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  task automatic test_directed();
    send_beat(CMD_QUERY, 32'sd0, 32'd0);
    send_beat(CMD_REMOVE_ONE, 32'sd5, 32'd0);
    send_beat(CMD_REMOVE_N, 32'sd5, 32'd0);
    send_beat(CMD_ADD, 32'sh8000_0000, 32'd0);
    send_beat(CMD_ADD, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_ADD, 32'sd0, 32'd0);
    send_beat(CMD_ADD, 32'sd0, 32'd0);
    send_beat(CMD_ADD, -32'sd1, 32'd0);
    send_beat(CMD_QUERY, 32'sd0, 32'd0);
    send_beat(CMD_QUERY, 32'sh7FFF_FFFF, 32'd0);
    send_beat(CMD_REMOVE_N, 32'sd0, 32'd0);
    send_beat(CMD_REMOVE_N, 32'sd0, 32'hFFFF_FFFF);
    send_beat(CMD_REMOVE_ONE, 32'sh8000_0000, 32'd0);
    send_beat(CMD_REMOVE_N, 32'sh7FFF_FFFF, 32'd1);
    send_beat(CMD_REMOVE_ONE, -32'sd1, 32'd0);
    send_beat(CMD_QUERY, -32'sd1, 32'd0);
  endtask

  task automatic test_store_full();
    for (int i = 0; i < CAP + 3; i++)
      send_beat(CMD_ADD, (i % 2) ? 32'sd1000 * i : -32'sd1000 * i - 7, 32'd0);
    send_beat(CMD_ADD, 32'sd1000, 32'd0);
    for (int i = 0; i < CAP + 3; i++)
      send_beat(CMD_REMOVE_N, (i % 2) ? 32'sd1000 * i : -32'sd1000 * i - 7,
                32'hFFFF_FFFF);
  endtask

  task automatic test_random();
    for (int i = 0; i < 950; i++) begin
      if (i > 800) begin
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
      end
      send_beat($urandom_range(0, 9) < 5 ? CMD_ADD : 2'($urandom_range(1, 3)),
                pick_value(), pick_amount());
    end
  endtask

  initial begin
    bag_clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_store_full();
    test_random();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("** sorted_multiset_linked_table: PASSED **");
    else $display("** sorted_multiset_linked_table: FAILED **");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** sorted_multiset_linked_table: FAILED **");
    $finish;
  end
endmodule
